@@ rtl/assert_macros.svh @@
// Assertion macros for the multiplicative persistence unit checkers.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define MPU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mpu assertion failed");

// implication on the next cycle
`define MPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mpu assertion failed");

`endif

@@ rtl/mpu_pkg.sv @@
// Shared types and constants of the multiplicative persistence unit.
// No dependencies.
package mpu_pkg;

	localparam int LEVELS_BITS = 4;
	localparam int DIGIT_BITS  = 4;
	localparam int DIGIT_MAX   = 9;

	typedef struct packed {
		logic start;
	} mpu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mpu_sts_t;

	// decimal digits needed for a number of the given bit width
	function automatic int bcd_digits(input int bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

endpackage

@@ rtl/mpu_bcd.sv @@
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on mpu_pkg.
module mpu_bcd import mpu_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  mpu_ctl_t                                     ctl,
	input  logic [VALUE_BITS-1:0]                        bin,
	output logic [bcd_digits(VALUE_BITS)*DIGIT_BITS-1:0] bcd,
	output mpu_sts_t                                     sts
);

	localparam int DIGITS = bcd_digits(VALUE_BITS);
	localparam int BCD_W  = DIGITS * DIGIT_BITS;
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      adj;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
				adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_q[i*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
			end else begin
				adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_q[i*DIGIT_BITS +: DIGIT_BITS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign bcd      = bcd_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

@@ rtl/mpu_dprod.sv @@
// Digit-serial product of the decimal digits, one digit per cycle from the low end.
// Depends on mpu_pkg.
module mpu_dprod import mpu_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  mpu_ctl_t                                     ctl,
	input  logic [bcd_digits(VALUE_BITS)*DIGIT_BITS-1:0] bcd,
	output logic [VALUE_BITS-1:0]                        prod,
	output mpu_sts_t                                     sts
);

	localparam int BCD_W = bcd_digits(VALUE_BITS) * DIGIT_BITS;

	logic [BCD_W-1:0]      rem_q;
	logic [VALUE_BITS-1:0] prod_q;
	logic [VALUE_BITS-1:0] mul;
	logic                  busy_q;
	logic                  rem_zero;

	// a partial digit product never exceeds the product of the nonzero digits, which fits VALUE_BITS
	assign mul      = prod_q * VALUE_BITS'(rem_q[DIGIT_BITS-1:0]);
	assign rem_zero = (rem_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && rem_zero) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= bcd;
			prod_q <= VALUE_BITS'(1);
		end else if (busy_q && !rem_zero) begin
			prod_q <= mul;
			rem_q  <= {{DIGIT_BITS{1'b0}}, rem_q[BCD_W-1:DIGIT_BITS]};
		end
	end

	assign prod     = prod_q;
	assign sts.busy = busy_q;
	assign sts.done = busy_q && rem_zero;

endmodule

@@ rtl/multiplicative_persistence_unit.sv @@
// channel | handshake          | fields
// in      | in_valid, in_stall  | value [VALUE_BITS]
// out     | out_valid, out_stall| levels [4]
//
// Each round takes a test state, a serial BCD conversion of the VALUE_BITS bits and
// a pass over the significant decimal digits in the digit multiplier.
// At 64 bits: at most eleven rounds per item.
// Reset clears the sequencer and the output valid; payload registers are not reset.
// A stalled result holds in the output register while the next transaction is taken.
// Top level; depends on mpu_pkg, mpu_bcd and mpu_dprod.
module multiplicative_persistence_unit import mpu_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_BITS-1:0]  value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [LEVELS_BITS-1:0] levels
);

	localparam int BCD_W = bcd_digits(VALUE_BITS) * DIGIT_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_CONV,
		ST_MUL,
		ST_HOLD
	} state_t;

	state_t                 state_q;
	logic [VALUE_BITS-1:0]  val_q;
	logic [LEVELS_BITS-1:0] cnt_q;
	logic [LEVELS_BITS-1:0] levels_q;
	logic                   out_valid_q;
	logic                   out_free;
	logic                   multi_digit;
	mpu_ctl_t               conv_ctl;
	mpu_ctl_t               mul_ctl;
	mpu_sts_t               conv_sts;
	mpu_sts_t               mul_sts;
	logic [BCD_W-1:0]       bcd;
	logic [VALUE_BITS-1:0]  prod;

	assign multi_digit    = (val_q > VALUE_BITS'(DIGIT_MAX));
	assign out_free       = !out_valid_q || !out_stall;
	assign conv_ctl.start = (state_q == ST_TEST) && multi_digit;
	assign mul_ctl.start  = (state_q == ST_CONV) && conv_sts.done;

	mpu_bcd #(.VALUE_BITS(VALUE_BITS)) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (conv_ctl),
		.bin    (val_q),
		.bcd    (bcd),
		.sts    (conv_sts)
	);

	mpu_dprod #(.VALUE_BITS(VALUE_BITS)) u_dprod (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.bcd    (bcd),
		.prod   (prod),
		.sts    (mul_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_HOLD) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					state_q <= multi_digit ? ST_CONV : ST_HOLD;
				end
				ST_CONV: begin
					if (conv_sts.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_sts.done) begin
						state_q <= ST_TEST;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			val_q <= value;
			cnt_q <= '0;
		end
		if (conv_ctl.start) begin
			cnt_q <= cnt_q + LEVELS_BITS'(1);
		end
		if (state_q == ST_MUL && mul_sts.done) begin
			val_q <= prod;
		end
		if (state_q == ST_HOLD && out_free) begin
			levels_q <= cnt_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign levels    = levels_q;

endmodule

@@ rtl/mpu_checker.sv @@
// Port-level checker of the multiplicative persistence unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mpu_checker #(
	parameter int VALUE_BITS = 64
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [VALUE_BITS-1:0] value,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [3:0]            levels
);

	logic in_take;

	assign in_take = in_valid && !in_stall;

	`MPU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(levels))
	`MPU_ASSERT_NOW(a_levels_range, clk, arst_n, out_valid, levels <= 4'd11)
	`MPU_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_take, in_stall)
	`MPU_ASSERT_NOW(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall))
	`MPU_ASSERT_NEXT(a_small_no_rush, clk, arst_n, in_take && value <= VALUE_BITS'(9), !$rose(out_valid))

endmodule

bind multiplicative_persistence_unit mpu_checker #(.VALUE_BITS(VALUE_BITS)) u_mpu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.value     (value),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.levels    (levels)
);

@@ sim/multiplicative_persistence_unit_test.sv @@
// Self-checking testbench of the multiplicative persistence unit: directed table, then random
// operands biased towards deep digit-product chains, checked against a built-in predictor.
// Depends on mpu_pkg and multiplicative_persistence_unit.
module multiplicative_persistence_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mpu_pkg::*;

	localparam int          VALUE_BITS    = 64;
	localparam int          RESET_CYCLES  = 6;
	localparam int          MAX_IDLE      = 19;
	localparam int          RANDOM_BLOCKS = 9;
	localparam int          BLOCK_ITEMS   = 50;
	localparam int          TAIL_CYCLES   = 1100;
	localparam int unsigned RUN_LIMIT_NS  = 5_000_000;
	localparam bit          GIVEN         = 1'b1;
	localparam bit          PREDICTED     = 1'b0;

	typedef struct packed {
		bit [VALUE_BITS-1:0]  num;
		bit                   given;
		bit [LEVELS_BITS-1:0] levels;
	} vector_row_t;

	typedef struct {
		bit [VALUE_BITS-1:0]  operand;
		bit [LEVELS_BITS-1:0] levels;
	} persistence_due_t;

	localparam int N_ROWS = 24;
	localparam vector_row_t DIRECTED_ROWS [N_ROWS] = '{
		{64'd0,                    GIVEN,     4'd0},
		{64'd1,                    GIVEN,     4'd0},
		{64'd9,                    GIVEN,     4'd0},
		{64'd10,                   GIVEN,     4'd1},
		{64'd11,                   GIVEN,     4'd1},
		{64'd25,                   GIVEN,     4'd2},
		{64'd39,                   GIVEN,     4'd3},
		{64'd77,                   GIVEN,     4'd4},
		{64'd679,                  GIVEN,     4'd5},
		{64'd6788,                 GIVEN,     4'd6},
		{64'd68889,                GIVEN,     4'd7},
		{64'd2677889,              GIVEN,     4'd8},
		{64'd26888999,             GIVEN,     4'd9},
		{64'd3778888999,           GIVEN,     4'd10},
		{64'd277777788888899,      GIVEN,     4'd11},
		{64'd100,                  GIVEN,     4'd1},
		{64'd1111111111111111111,  GIVEN,     4'd1},
		{64'd10000000000000000000, GIVEN,     4'd1},
		{64'hFFFF_FFFF_FFFF_FFFF,  PREDICTED, 4'd0},
		{64'd9999999999999999999,  PREDICTED, 4'd0},
		{64'h8000_0000_0000_0000,  PREDICTED, 4'd0},
		{64'h5555_5555_5555_5555,  PREDICTED, 4'd0},
		{64'hAAAA_AAAA_AAAA_AAAA,  PREDICTED, 4'd0},
		{64'd99,                   PREDICTED, 4'd0}
	};

	localparam bit [VALUE_BITS-1:0] DEEP_VALUES [5] = '{
		64'd277777788888899, 64'd3778888999, 64'd26888999, 64'd2677889, 64'd68889
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [VALUE_BITS-1:0]  value;
	logic                   out_valid;
	logic                   out_stall;
	logic [LEVELS_BITS-1:0] levels;

	bit               idle_on;
	int unsigned      mismatch_count = 0;
	persistence_due_t levels_due [$];

	multiplicative_persistence_unit #(
		.VALUE_BITS(VALUE_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.levels    (levels)
	);

	always #1 clk = ~clk;

	function automatic bit [LEVELS_BITS-1:0] persistence_levels(input bit [VALUE_BITS-1:0] n);
		bit [VALUE_BITS-1:0] v;
		bit [VALUE_BITS-1:0] prod;
		bit [VALUE_BITS-1:0] digits_left;
		int                  rounds;
		v = n;
		rounds = 0;
		while (v > 9) begin
			prod = 1;
			digits_left = v;
			while (digits_left != 0) begin
				prod = prod * (digits_left % 10);
				digits_left = digits_left / 10;
			end
			v = prod;
			rounds++;
		end
		return rounds[LEVELS_BITS-1:0];
	endfunction

	function automatic bit [VALUE_BITS-1:0] random_operand();
		int unsigned         kind;
		int unsigned         ndig;
		int                  zero_at;
		int                  j;
		int                  k;
		bit [VALUE_BITS-1:0] d;
		bit [VALUE_BITS-1:0] rec;
		bit [VALUE_BITS-1:0] n;
		bit [VALUE_BITS-1:0] digs [$];
		kind = $urandom_range(0, 19);
		n = 0;
		if (kind < 8 || kind >= 18) begin
			ndig = $urandom_range(2, 19);
			zero_at = (kind >= 18) ? int'($urandom_range(0, ndig - 1)) : -1;
			for (j = 0; j < int'(ndig); j++) begin
				d = $urandom_range(0, 1) ? $urandom_range(6, 9) : $urandom_range(1, 9);
				if (j == zero_at)
					d = 0;
				n = n * 10 + d;
			end
		end else if (kind < 12) begin
			rec = DEEP_VALUES[$urandom_range(0, $size(DEEP_VALUES) - 1)];
			while (rec != 0) begin
				digs.push_back(rec % 10);
				rec = rec / 10;
			end
			repeat ($urandom_range(0, 19 - digs.size())) digs.push_back(1);
			for (j = digs.size() - 1; j > 0; j--) begin
				k = $urandom_range(0, j);
				d = digs[j];
				digs[j] = digs[k];
				digs[k] = d;
			end
			foreach (digs[i])
				n = n * 10 + digs[i];
		end else if (kind < 14) begin
			n = 1;
			n = n * 10 + $urandom_range(1, 7);
			repeat (18) n = n * 10 + $urandom_range(1, 9);
		end else if (kind < 16) begin
			n = {$urandom, $urandom};
		end else if (kind == 16) begin
			n = $urandom_range(0, 99);
		end else begin
			n = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 1000);
		end
		return n;
	endfunction

	task automatic log_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic offer_operand(input bit [VALUE_BITS-1:0] n,
			input bit [LEVELS_BITS-1:0] due_levels);
		int unsigned      gap;
		persistence_due_t entry;
		gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= n;
		do @(posedge clk); while (in_stall !== 1'b0);
		entry.operand = n;
		entry.levels  = due_levels;
		levels_due.push_back(entry);
	endtask

	task automatic hold_until_drained();
		while (levels_due.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		bit [VALUE_BITS-1:0] operand;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		value     = '0;
		out_stall = 1'b0;
		idle_on   = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_ROWS; i++) begin
			operand = DIRECTED_ROWS[i].num;
			offer_operand(operand, DIRECTED_ROWS[i].given ? DIRECTED_ROWS[i].levels
				: persistence_levels(operand));
		end
		in_valid <= 1'b0;
		hold_until_drained();

		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if (blk == RANDOM_BLOCKS / 2) begin
				in_valid <= 1'b0;
				hold_until_drained();
			end
			repeat (BLOCK_ITEMS) begin
				operand = random_operand();
				offer_operand(operand, persistence_levels(operand));
			end
		end
		in_valid <= 1'b0;

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("multiplicative_persistence_unit_test: PASS");
		else
			$display("multiplicative_persistence_unit_test: FAIL");
		$finish;
	end

	initial begin : result_side
		int unsigned      hold;
		persistence_due_t due;
		wait (arst_n === 1'b1);
		forever begin
			hold = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
			if (levels_due.size() == 0) begin
				log_mismatch($sformatf("result levels=%0d with no transaction pending", levels));
			end else begin
				due = levels_due.pop_front();
				if (levels !== due.levels)
					log_mismatch($sformatf("value=%0d levels=%0d, predicted %0d",
						due.operand, levels, due.levels));
			end
		end
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("multiplicative_persistence_unit_test: FAIL");
		$finish;
	end

endmodule
